// ----- src/swec_pkg.sv -----
// swec_pkg: shared types and constants for the sliding window event counter.
// No dependencies; imported by swec_ctrl, swec_dp and the top level.
package swec_pkg;

  localparam int STORE_DEPTH_DEF = 1024;
  localparam int TS_W            = 63;
  localparam int WIN_W           = 31;
  localparam int LIVE_W          = 11;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 31'd1000000000;

  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_EXPIRE
  } swec_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming beat
    logic pop;      // drop the oldest stored hit
    logic finish;   // record (if asked), load result register
  } swec_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic head_expired;  // store not empty and oldest hit is out of window
  } swec_stat_t;

endpackage

// ----- src/swec_ctrl.sv -----
// swec_ctrl: controller FSM of the sliding window event counter.
// Depends on swec_pkg (state enum, command and status structs).
module swec_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  swec_pkg::swec_stat_t  stat,
  output swec_pkg::swec_cmd_t   cmd
);
  import swec_pkg::*;

  swec_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXPIRE;
      end
      S_EXPIRE: begin
        if (!stat.head_expired && slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXPIRE: begin
        cmd.pop    = stat.head_expired;
        cmd.finish = !stat.head_expired && slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/swec_dp.sv -----
// swec_dp: datapath of the sliding window event counter: hit FIFO memory,
// pointers, occupancy, window register, expiry compare and result register.
// Depends on swec_pkg.
module swec_dp #(
  parameter int STORE_DEPTH = swec_pkg::STORE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [swec_pkg::WIN_W-1:0]   cfg_wdata,
  input  logic                         in_operation,
  input  logic [swec_pkg::TS_W-1:0]    in_timestamp,
  input  swec_pkg::swec_cmd_t          cmd,
  output swec_pkg::swec_stat_t         stat,
  output logic [swec_pkg::LIVE_W-1:0]  out_live_count,
  output logic                         out_overflow
);
  import swec_pkg::*;

  localparam int PW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(STORE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(STORE_DEPTH);

  logic [TS_W-1:0]  mem [STORE_DEPTH];
  logic [TS_W-1:0]  head_r;
  logic [WIN_W-1:0] win_r;
  logic [TS_W-1:0]  now_r;
  logic             op_r;
  logic [PW-1:0]    oldest_r, oldest_nxt;
  logic [PW-1:0]    newest_r, newest_nxt;
  logic [CW-1:0]    occ_r, occ_nxt;
  logic             full, push, expired;
  logic [TS_W:0]    limit;
  logic [CW+LIVE_W-1:0] cnt_ext;
  logic [LIVE_W-1:0] live_r;
  logic              ovf_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  // hit + window < now, formed one bit wider so it cannot wrap
  assign limit   = {1'b0, head_r} + {{(TS_W + 1 - WIN_W){1'b0}}, win_r};
  assign expired = (occ_r != '0) && (limit < {1'b0, now_r});
  assign stat.head_expired = expired;

  assign full = (occ_r == CNT_FULL);
  assign push = cmd.finish && (op_r == OP_RECORD) && !full;

  always_comb begin
    oldest_nxt = cmd.pop ? ptr_inc(oldest_r) : oldest_r;
    newest_nxt = push ? ptr_inc(newest_r) : newest_r;
    occ_nxt    = occ_r;
    if (cmd.pop) occ_nxt = occ_r - CW'(1);
    else if (push) occ_nxt = occ_r + CW'(1);
  end

  assign cnt_ext = {{LIVE_W{1'b0}}, occ_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= WINDOW_RESET;
      oldest_r <= '0;
      newest_r <= '0;
      occ_r    <= '0;
    end else begin
      if (cfg_we) win_r <= cfg_wdata;
      oldest_r <= oldest_nxt;
      newest_r <= newest_nxt;
      occ_r    <= occ_nxt;
    end
  end

  // head_r always holds the entry at the oldest pointer; bypass on write
  always_ff @(posedge clk) begin
    if (push) mem[newest_r] <= now_r;
    if (push && (newest_r == oldest_nxt)) head_r <= now_r;
    else head_r <= mem[oldest_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r <= in_timestamp;
      op_r  <= in_operation;
    end
    if (cmd.finish) begin
      live_r <= cnt_ext[LIVE_W-1:0];
      ovf_r  <= (op_r == OP_RECORD) && full;
    end
  end

  assign out_live_count = live_r;
  assign out_overflow   = ovf_r;

endmodule

// ----- src/sliding_window_event_counter.sv -----
// sliding_window_event_counter: top level; ties controller and datapath.
// Depends on swec_pkg, swec_ctrl and swec_dp.
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item: an
//   operation (0 = query, 1 = record a hit) and a nondecreasing timestamp.
//   Output channel (out_valid/out_ready) returns one beat per item: the
//   number of live hits after the item and an overflow flag that is set
//   when a record was dropped because the hit store was full.
//   cfg_we/cfg_wdata write the window length in ticks; write only while
//   the block is idle.
// Timing:
//   An item is taken in the idle state; in the expire state the store
//   then pops one expired hit per cycle on its read port, and a final
//   step records the item (if asked) and loads the result register.
//   Each hit expires once. A new item is taken only after the previous
//   one has had its final step. Result appears on the output the cycle
//   after the final step.
// Reset: store emptied (pointers and count cleared, memory left as is),
//   window back to 1000000000 ticks.
// Stall: a waiting result sits in the output register; the next item is
//   still accepted and expired, and only its final step waits for the slot.
module sliding_window_event_counter #(
  parameter int STORE_DEPTH = swec_pkg::STORE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [swec_pkg::WIN_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [swec_pkg::TS_W-1:0]    in_timestamp,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [swec_pkg::LIVE_W-1:0]  out_live_count,
  output logic                         out_overflow
);
  import swec_pkg::*;

  swec_cmd_t  cmd;   // controller commands
  swec_stat_t stat;  // datapath status

  swec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swec_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_operation   (in_operation),
    .in_timestamp   (in_timestamp),
    .cmd            (cmd),
    .stat           (stat),
    .out_live_count (out_live_count),
    .out_overflow   (out_overflow)
  );

endmodule
